/* design/olsd_pkg.sv */
// shared types and constants for the ordered list search/delete core
// no dependencies; imported by olsd_cell, olsd_chain and the top level
package olsd_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      REQ_APPEND = 3'd0,
      REQ_DUMP   = 3'd1,
      REQ_SEARCH = 3'd2,
      REQ_POP    = 3'd3,
      REQ_DELETE = 3'd4
   } olsd_req_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_NOTFOUND = 2'd2,
      STAT_FULL     = 2'd3
   } olsd_status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_POP,
      CELL_DELETE,
      CELL_ROTATE
   } olsd_cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } olsd_state_type;

   typedef struct packed {
      olsd_cell_op_type  op;
      logic [DATA_W-1:0] key;
      logic [CNT_W-1:0]  count;
   } olsd_cell_ctrl_type;

endpackage

/* design/ordered_list_search_delete_core.sv */
// top level of the ordered list search/delete core
// depends on olsd_pkg and olsd_chain (which holds the olsd_cell row)
//
// bounded list of up to DEPTH signed 32-bit entries kept in insertion
// order in a row of cells, slot 0 being the head. append, search, remove
// head and remove by key each take one request transaction and give one
// result transaction, registered in the cycle after acceptance; search and
// keyed removal compare the key in every cell at once, and keyed removal
// moves the later entries up one cell in that same cycle. a dump gives
// one result per held entry, one per cycle while the result side keeps
// up: the chain rotates the occupied cells by one for each result and the
// head cell feeds the output, which leaves the list in its original order
// at the end. a request is taken when no dump is running and the result
// register is empty or being emptied. requests with an unused type are
// taken and give no result. entry contents are not reset; only slots
// below the count are ever read
module ordered_list_search_delete_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] data
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);
   import olsd_pkg::*;

   // control state
   olsd_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   dump_idx_ff, dump_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   // result payload
   olsd_status_type    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   olsd_cell_ctrl_type cell_ctrl;
   olsd_cell_op_type   cell_op;
   olsd_req_type       req_kind;
   logic [DATA_W-1:0]  head_value;
   logic               found;
   logic               out_free;
   logic               req_fire;
   logic               dump_last;

   assign req_kind  = olsd_req_type'(req_tuser);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_fire  = req_tvalid && req_tready;
   assign dump_last = (CNT_W'(dump_idx_ff) + CNT_W'(1)) == count_ff;

   assign cell_ctrl.op    = cell_op;
   assign cell_ctrl.key   = req_tdata;
   assign cell_ctrl.count = count_ff;

   olsd_chain u_chain (
      .clock      (clock),
      .ctrl       (cell_ctrl),
      .head_value (head_value),
      .found      (found)
   );

   // next state, cell command and result register load
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      cell_op       = CELL_HOLD;
      req_tready    = (state_ff == ST_IDLE) && out_free;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
               if (req_kind == REQ_APPEND) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == DEPTH_CNT) begin
                     rsp_status_in = STAT_FULL;
                  end else begin
                     cell_op       = CELL_APPEND;
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = STAT_OK;
                  end
               end else if (count_ff == '0) begin
                  // anything but append on an empty list, unused codes aside
                  case (req_kind)
                     REQ_DUMP, REQ_SEARCH, REQ_POP, REQ_DELETE: begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end
                     default: rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  endcase
               end else begin
                  case (req_kind)
                     REQ_DUMP: begin
                        state_in    = ST_DUMP;
                        dump_idx_in = '0;
                     end
                     REQ_SEARCH: begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = found ? STAT_OK : STAT_NOTFOUND;
                     end
                     REQ_POP: begin
                        cell_op       = CELL_POP;
                        count_in      = count_ff - CNT_W'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_OK;
                     end
                     REQ_DELETE: begin
                        rsp_valid_in = 1'b1;
                        if (found) begin
                           cell_op       = CELL_DELETE;
                           count_in      = count_ff - CNT_W'(1);
                           rsp_status_in = STAT_OK;
                        end else begin
                           rsp_status_in = STAT_NOTFOUND;
                        end
                     end
                     default: rsp_valid_in = rsp_valid_ff && !rsp_tready;
                  endcase
               end
            end
         end
         ST_DUMP: begin
            // head cell out, chain rotates by one
            if (out_free) begin
               cell_op       = CELL_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_data_in   = head_value;
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_idx_ff + IDX_W'(1);
               if (dump_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // the list never holds more than DEPTH entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond depth");

   // a running dump only walks held entries
   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> (CNT_W'(dump_idx_ff) < count_ff))
      else $error("dump index past tail");

   // an append into a list with room adds exactly one entry
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind == REQ_APPEND && count_ff != DEPTH_CNT
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the list");

   // an error status always comes with the last marker; only dump entries can be followed by more results
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_OK |-> rsp_last_ff)
      else $error("error status without last marker");

   // no request is taken while a dump is running
   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> !req_fire)
      else $error("request taken during dump");

endmodule

/* design/olsd_cell.sv */
// one slot of the list: holds an entry and moves it along the chain
// depends on olsd_pkg
module olsd_cell (
   input  logic                        clock,
   input  olsd_pkg::olsd_cell_ctrl_type ctrl,
   input  logic [olsd_pkg::IDX_W-1:0]  slot,
   input  logic [olsd_pkg::DATA_W-1:0] next_value,
   input  logic [olsd_pkg::DATA_W-1:0] head_value,
   input  logic                        match_prior,
   output logic [olsd_pkg::DATA_W-1:0] value,
   output logic                        match_through
);
   import olsd_pkg::*;

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic [CNT_W-1:0]  slot_ext;
   logic              occupied;
   logic              is_tail;
   logic              hit;

   assign slot_ext      = CNT_W'(slot);
   assign occupied      = slot_ext < ctrl.count;
   assign is_tail       = (slot_ext + CNT_W'(1)) == ctrl.count;
   assign hit           = occupied && (value_ff == ctrl.key);
   assign match_through = match_prior || hit;
   assign value         = value_ff;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         CELL_APPEND: begin
            if (slot_ext == ctrl.count) value_in = ctrl.key;
         end
         CELL_POP: begin
            if (occupied) value_in = next_value;
         end
         CELL_DELETE: begin
            // first match and everything behind it move up one slot
            if (occupied && match_through) value_in = next_value;
         end
         CELL_ROTATE: begin
            if (is_tail) value_in = head_value;
            else if (occupied) value_in = next_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* design/olsd_chain.sv */
// row of list cells with the first-match chain and head tap
// depends on olsd_pkg and olsd_cell
module olsd_chain (
   input  logic                        clock,
   input  olsd_pkg::olsd_cell_ctrl_type ctrl,
   output logic [olsd_pkg::DATA_W-1:0] head_value,
   output logic                        found
);
   import olsd_pkg::*;

   logic [DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]  match_chain;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] next_v;
      logic              prior;
      if (i == DEPTH - 1) begin : g_end
         assign next_v = '0;
      end else begin : g_mid
         assign next_v = cell_value[i+1];
      end
      if (i == 0) begin : g_first
         assign prior = 1'b0;
      end else begin : g_rest
         assign prior = match_chain[i-1];
      end
      olsd_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .slot          (IDX_W'(i)),
         .next_value    (next_v),
         .head_value    (cell_value[0]),
         .match_prior   (prior),
         .value         (cell_value[i]),
         .match_through (match_chain[i])
      );
   end

   assign head_value = cell_value[0];
   assign found      = match_chain[DEPTH-1];

endmodule
